@@ hdl/dsot_pkg.sv @@
// Package for the depth-sorted object table: opcodes, status codes, entry record.
// No dependencies.
package dsot_pkg;

	localparam int unsigned CapacityDefault = 256;

	typedef enum logic [2:0] {
		OP_PLACE   = 3'd0,
		OP_MOVE    = 3'd1,
		OP_REPLACE = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_CLEAR   = 3'd4,
		OP_SWEEP   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_MISSING  = 3'd2,
		ST_FULL     = 3'd3,
		ST_DONE     = 3'd4
	} status_t;

	// One table row; the mark travels with the row.
	typedef struct packed {
		logic [15:0] depth;
		logic [15:0] char_id;
		logic        marked;
		logic [31:0] color;
		logic [31:0] xform;
		logic [15:0] ratio;
		logic [15:0] mask;
	} entry_t;

endpackage

@@ hdl/dsot_ram.sv @@
// Entry store: one write port, one registered read port.
// Depends on dsot_pkg.
module dsot_ram #(
	parameter int unsigned CAPACITY = dsot_pkg::CapacityDefault,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  dsot_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output dsot_pkg::entry_t rdata
);
	import dsot_pkg::*;

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/depth_sorted_object_table.sv @@
// Depth-sorted object table: sequencer around a one-read, one-write entry RAM.
// Depends on dsot_pkg, dsot_ram.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  command   | start / busy       | op, depth, char_id, use_color, use_transform,
//            |                    | color_handle, transform_handle, morph_ratio,
//            |                    | mask_depth
//  result    | done (1-cycle)     | status, slot, live_count
//
// A command transfers when start is high and busy low. Each binary search
// halving step issues a RAM read, waits, then compares. Insert shifts each
// entry at or above the insert point up one row; sweep and mark reset walk
// every live entry; all loops run through the one RAM read port.
// Reset clears the entry count, sequencer and command registers but not the RAM;
// the RAM holds no valid bits since rows at or above the count are never used. The receiver cannot stall:
// done is a one-cycle strobe and busy falls in the same cycle.
module depth_sorted_object_table #(
	parameter int unsigned CAPACITY = dsot_pkg::CapacityDefault,
	localparam int unsigned AW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [15:0] depth,
	input  logic [15:0] char_id,
	input  logic        use_color,
	input  logic        use_transform,
	input  logic [31:0] color_handle,
	input  logic [31:0] transform_handle,
	input  logic [15:0] morph_ratio,
	input  logic [15:0] mask_depth,
	output logic        done,
	output logic [2:0]  status,
	output logic [8:0]  slot,
	output logic [8:0]  live_count
);
	import dsot_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SWAIT, S_SCMP, S_EWAIT, S_ECHK,
		S_SHRD, S_SHWAIT, S_SHWR, S_WRITE,
		S_SWRD, S_SWWAIT, S_SWWR, S_FIN
	} state_t;

	state_t           state_q;
	logic [2:0]       op_q;
	logic [15:0]      depth_q, char_q, ratio_q, mask_q;
	logic             ucol_q, uxf_q;
	logic [31:0]      col_q, xf_q;
	logic [CW-1:0]    total_q, lo_q, hi_q, idx_q, wr_q;
	logic [2:0]       status_q;
	logic [CW-1:0]    slot_q;
	entry_t           hit_q;
	logic             done_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	entry_t           wdata, rdata;
	logic [CW-1:0]    mid;

	// Midpoint of the live search window.
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	dsot_ram #(.CAPACITY(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Read address per state.
	always_comb begin
		raddr = mid[AW-1:0];
		unique case (state_q)
			S_SRCH, S_SWAIT, S_SCMP: raddr = mid[AW-1:0];
			S_SHRD, S_SHWAIT, S_SHWR: raddr = AW'(idx_q - CW'(1));
			default: raddr = lo_q[AW-1:0];
		endcase
	end

	// Write port: shift writes row idx from row idx-1, sweep writes compacted row,
	// mark reset clears the row's mark in place, final write updates the target row.
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		unique case (state_q)
			S_SHWR: begin
				we = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
			end
			S_SWWR: begin
				we = rdata.marked || (op_q == OP_CLEAR);
				waddr = (op_q == OP_CLEAR) ? lo_q[AW-1:0] : wr_q[AW-1:0];
				wdata = rdata;
				if (op_q == OP_CLEAR) begin
					wdata.marked = 1'b0;
				end
			end
			S_WRITE: begin
				we = 1'b1;
				waddr = slot_q[AW-1:0];
				wdata = hit_q;
				wdata.ratio = ratio_q;
				wdata.mask = mask_q;
				unique case (op_q)
					OP_PLACE: begin
						wdata.depth = depth_q;
						wdata.char_id = char_q;
						wdata.marked = 1'b1;
						wdata.color = col_q;
						wdata.xform = xf_q;
					end
					OP_REMOVE: begin
						wdata = hit_q;
						wdata.marked = 1'b0;
					end
					default: begin
						if (op_q == OP_REPLACE) begin
							wdata.char_id = char_q;
							wdata.marked = 1'b1;
						end
						if (ucol_q) wdata.color = col_q;
						if (uxf_q) wdata.xform = xf_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_DONE;
			slot_q <= '0;
			op_q <= '0; depth_q <= '0; char_q <= '0;
			ucol_q <= 1'b0; uxf_q <= 1'b0;
			col_q <= '0; xf_q <= '0;
			ratio_q <= '0; mask_q <= '0;
			lo_q <= '0; hi_q <= '0; idx_q <= '0; wr_q <= '0;
			hit_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= op; depth_q <= depth; char_q <= char_id;
						ucol_q <= use_color; uxf_q <= use_transform;
						col_q <= color_handle; xf_q <= transform_handle;
						ratio_q <= morph_ratio; mask_q <= mask_depth;
						lo_q <= '0; hi_q <= total_q; wr_q <= '0;
						status_q <= ST_DONE; slot_q <= '0;
						if (op <= OP_REMOVE) state_q <= S_SRCH;
						else if (op == OP_CLEAR || op == OP_SWEEP) state_q <= S_SWRD;
						else state_q <= S_FIN;
					end
				end
				// Binary search for the lower bound.
				S_SRCH: state_q <= (lo_q < hi_q) ? S_SWAIT : S_EWAIT;
				S_SWAIT: state_q <= S_SCMP;
				S_SCMP: begin
					if (rdata.depth < depth_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= S_SRCH;
				end
				// raddr = lo: read candidate row.
				S_EWAIT: state_q <= S_ECHK;
				S_ECHK: begin
					slot_q <= lo_q;
					hit_q <= rdata;
					idx_q <= total_q;
					if (op_q == OP_PLACE) begin
						if (lo_q < total_q && rdata.depth == depth_q
								&& rdata.char_id == char_q) begin
							status_q <= ST_UPDATED; state_q <= S_WRITE;
						end else if (total_q >= CW'(CAPACITY)) begin
							status_q <= ST_FULL; state_q <= S_FIN;
						end else begin
							status_q <= ST_INSERTED; total_q <= total_q + CW'(1);
							state_q <= S_SHRD;
						end
					end else if (lo_q < total_q && rdata.depth == depth_q) begin
						status_q <= ST_UPDATED; state_q <= S_WRITE;
					end else begin
						status_q <= ST_MISSING; state_q <= S_FIN;
					end
				end
				// Shift rows up from the top down to the insert point.
				S_SHRD: state_q <= (idx_q > slot_q) ? S_SHWAIT : S_WRITE;
				S_SHWAIT: state_q <= S_SHWR;
				S_SHWR: begin
					idx_q <= idx_q - CW'(1);
					state_q <= S_SHRD;
				end
				S_WRITE: state_q <= S_FIN;
				// Mark reset / sweep: walk live rows, lo is the read pointer.
				S_SWRD: begin
					if (lo_q < total_q) state_q <= S_SWWAIT;
					else begin
						if (op_q == OP_SWEEP) total_q <= wr_q;
						state_q <= S_FIN;
					end
				end
				S_SWWAIT: state_q <= S_SWWR;
				S_SWWR: begin
					if (rdata.marked) wr_q <= wr_q + CW'(1);
					lo_q <= lo_q + CW'(1);
					state_q <= S_SWRD;
				end
				S_FIN: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign slot = 9'(slot_q);
	assign live_count = 9'(total_q);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for depth_sorted_object_table: directed and random table operations.
// Depends on dsot_pkg and the depth_sorted_object_table RTL.

module tb;
	import dsot_pkg::*;

	localparam int unsigned CAP       = 256;
	localparam int unsigned RAND_ITEMS = 1670;
	localparam int unsigned DOG_LIMIT = 20000;

	// Result expected for one accepted command.
	typedef struct {
		logic [2:0] status;
		logic [8:0] slot;
		logic [8:0] live_count;
	} table_result_t;

	// Mirror of the object table plus the queue of pending results.
	class table_scoreboard;
		entry_t          rows[CAP];
		int unsigned     total;
		table_result_t   pending[$];
		int unsigned     errors;
		int unsigned     checked;

		function void clear();
			total = 0;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function int unsigned lower_bound(logic [15:0] key);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = total;
			while (lo < hi) begin
				mid = lo + ((hi - lo) >> 1);
				if (rows[mid].depth < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		// Apply one accepted command to the mirror and queue its result.
		function void note_command(logic [2:0] opc, logic [15:0] dep, logic [15:0] cid,
			logic uc, logic ut, logic [31:0] col, logic [31:0] xf,
			logic [15:0] rat, logic [15:0] msk);
			table_result_t r;
			int unsigned idx;
			int unsigned w;
			bit exact;
			r.status = ST_DONE;
			r.slot = '0;
			if (opc <= OP_REMOVE) begin
				idx = lower_bound(dep);
				r.slot = idx[8:0];
				exact = (idx < total) && (rows[idx].depth == dep);
				if (opc == OP_PLACE) begin
					if (exact && rows[idx].char_id == cid)
						r.status = ST_UPDATED;
					else if (total >= CAP)
						r.status = ST_FULL;
					else begin
						for (int i = total; i > idx; i--)
							rows[i] = rows[i - 1];
						total++;
						rows[idx].depth = dep;
						rows[idx].char_id = cid;
						r.status = ST_INSERTED;
					end
					if (r.status != ST_FULL) begin
						rows[idx].marked = 1'b1;
						rows[idx].color = col;
						rows[idx].xform = xf;
						rows[idx].ratio = rat;
						rows[idx].mask = msk;
					end
				end else if (!exact)
					r.status = ST_MISSING;
				else begin
					r.status = ST_UPDATED;
					if (opc == OP_REMOVE)
						rows[idx].marked = 1'b0;
					else begin
						if (opc == OP_REPLACE) begin
							rows[idx].char_id = cid;
							rows[idx].marked = 1'b1;
						end
						if (uc) rows[idx].color = col;
						if (ut) rows[idx].xform = xf;
						rows[idx].ratio = rat;
						rows[idx].mask = msk;
					end
				end
			end else if (opc == OP_CLEAR) begin
				for (int i = 0; i < total; i++)
					rows[i].marked = 1'b0;
			end else if (opc == OP_SWEEP) begin
				w = 0;
				for (int i = 0; i < total; i++)
					if (rows[i].marked) begin
						rows[w] = rows[i];
						w++;
					end
				total = w;
			end
			r.live_count = total[8:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [8:0] sl, logic [8:0] lc);
			table_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d live=%0d",
					$realtime, st, sl, lc);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$display("%0t: status mismatch expected %0d actual %0d", $realtime, e.status, st);
				errors++;
			end
			if (sl !== e.slot) begin
				$display("%0t: slot mismatch expected %0d actual %0d", $realtime, e.slot, sl);
				errors++;
			end
			if (lc !== e.live_count) begin
				$display("%0t: live_count mismatch expected %0d actual %0d",
					$realtime, e.live_count, lc);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  op;
	logic [15:0] depth;
	logic [15:0] char_id;
	logic        use_color;
	logic        use_transform;
	logic [31:0] color_handle;
	logic [31:0] transform_handle;
	logic [15:0] morph_ratio;
	logic [15:0] mask_depth;
	logic        done;
	logic [2:0]  status;
	logic [8:0]  slot;
	logic [8:0]  live_count;

	table_scoreboard table_sb;
	int unsigned     idle_cycles;
	bit              sender_gaps;
	int unsigned     cmd_count;
	int unsigned     op_seen[8];

	depth_sorted_object_table #(.CAPACITY(CAP)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .depth(depth),
		.char_id(char_id), .use_color(use_color), .use_transform(use_transform),
		.color_handle(color_handle), .transform_handle(transform_handle),
		.morph_ratio(morph_ratio), .mask_depth(mask_depth), .done(done),
		.status(status), .slot(slot), .live_count(live_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample results and command transfers on the same edge the DUT sees them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				table_sb.check_result(status, slot, live_count);
			if (start && !busy) begin
				table_sb.note_command(op, depth, char_id, use_color, use_transform,
					color_handle, transform_handle, morph_ratio, mask_depth);
				op_seen[op]++;
			end
		end
	end

	// Watchdog: long sweeps walk every entry, so the limit is generous.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= DOG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", DOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Issue one command; start stays high until the transfer edge.
	task automatic send_cmd(logic [2:0] o, logic [15:0] d, logic [15:0] c,
		logic uc, logic ut, logic [31:0] col, logic [31:0] xf,
		logic [15:0] r, logic [15:0] m);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		depth <= d;
		char_id <= c;
		use_color <= uc;
		use_transform <= ut;
		color_handle <= col;
		transform_handle <= xf;
		morph_ratio <= r;
		mask_depth <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
		cmd_count++;
	endtask

	task automatic send_rand(logic [2:0] o, logic [15:0] d, logic [15:0] c);
		send_cmd(o, d, c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom, $urandom,
			$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom),
			$urandom_range(0, 2) == 0 ? 16'h0 : 16'($urandom));
	endtask

	// Hold start low until every queued result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (table_sb.pending.size() != 0) @(posedge clk);
	endtask

	// Pick a depth that mostly hits live entries so move/replace/remove find targets.
	function automatic logic [15:0] pick_depth(int unsigned span);
		int unsigned k;
		if (table_sb.total != 0 && $urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, table_sb.total - 1);
			return table_sb.rows[k].depth;
		end
		return 16'($urandom_range(0, span));
	endfunction

	initial begin
		logic [2:0]  o;
		logic [15:0] d;
		int unsigned span;
		table_sb = new();
		table_sb.clear();
		idle_cycles = 0;
		sender_gaps = 1'b0;
		cmd_count = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;
		depth = '0;
		char_id = '0;
		use_color = 1'b0;
		use_transform = 1'b0;
		color_handle = '0;
		transform_handle = '0;
		morph_ratio = '0;
		mask_depth = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: misses on an empty table, extremes, duplicates, unused codes.
		send_cmd(OP_MOVE, 16'h0, 16'h0, 1'b1, 1'b1, '1, '1, 16'hFFFF, 16'hFFFF);
		send_cmd(OP_REMOVE, 16'hFFFF, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_REPLACE, 16'h1234, 16'h1, 1'b1, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_PLACE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '1, '1, 16'hFFFF, 16'hFFFF);
		send_cmd(OP_PLACE, 16'h0, 16'h0, 1'b1, 1'b1, '0, '0, 16'h0, 16'h0);
		send_cmd(OP_PLACE, 16'h8000, 16'h5, 1'b0, 1'b1, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
			16'h8000, 16'h1);
		send_cmd(OP_PLACE, 16'h8000, 16'h5, 1'b1, 1'b0, 32'h1, 32'h2, 16'h3, 16'h4);
		send_cmd(OP_PLACE, 16'h8000, 16'h6, 1'b1, 1'b1, 32'h7, 32'h8, 16'h9, 16'hA);
		send_cmd(OP_MOVE, 16'h8000, 16'h0, 1'b1, 1'b0, 32'hFFFF_0000, 32'h0, 16'hFFFF, 16'h0);
		send_cmd(OP_REPLACE, 16'hFFFF, 16'h7777, 1'b0, 1'b1, 32'h0, 32'hDEAD_BEEF,
			16'h1, 16'h2);
		send_cmd(OP_REMOVE, 16'h8000, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_REMOVE, 16'h7FFF, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_SWEEP, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(3'd6, 16'h1, 16'h1, 1'b1, 1'b1, '1, '1, '1, '1);
		send_cmd(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '1, '1, '1, '1);
		send_cmd(OP_CLEAR, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_REPLACE, 16'h0, 16'hAAAA, 1'b1, 1'b1, 32'h1, 32'h1, 16'h1, 16'h1);
		send_cmd(OP_SWEEP, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		drain();

		// Fill the table to capacity, place into the full table, then reset marks and sweep.
		sender_gaps = 1'b1;
		while (table_sb.total < CAP)
			send_rand(OP_PLACE, 16'($urandom), 16'($urandom));
		send_rand(OP_PLACE, 16'h4000, 16'($urandom));
		send_rand(OP_PLACE, table_sb.rows[CAP - 1].depth, table_sb.rows[CAP - 1].char_id);
		send_cmd(OP_CLEAR, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		send_cmd(OP_SWEEP, 16'h0, 16'h0, 1'b0, 1'b0, '0, '0, '0, '0);
		drain();

		// Random: small depth ranges give duplicates and frequent hits.
		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS - 150) sender_gaps = 1'b0;
			if (n % 400 == 200) drain();
			span = (n % 600 < 300) ? 63 : 65535;
			case ($urandom_range(0, 99)) inside
				[0:39]:  o = OP_PLACE;
				[40:54]: o = OP_MOVE;
				[55:69]: o = OP_REPLACE;
				[70:87]: o = OP_REMOVE;
				[88:92]: o = OP_CLEAR;
				[93:97]: o = OP_SWEEP;
				default: o = 3'($urandom_range(6, 7));
			endcase
			d = pick_depth(span);
			send_rand(o, d, $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom));
		end

		// Let the last result come out, with a bounded wait.
		start <= 1'b0;
		@(posedge clk);
		for (int unsigned w = 0; w < DOG_LIMIT && table_sb.pending.size() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (table_sb.pending.size() != 0) begin
			$display("%0d results never arrived", table_sb.pending.size());
			table_sb.errors++;
		end
		$display("Ran %0d commands (place %0d, move %0d, replace %0d, remove %0d)",
			cmd_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
		$display("  mark resets %0d, sweeps %0d, unused codes %0d; %0d results checked",
			op_seen[4], op_seen[5], op_seen[6] + op_seen[7], table_sb.checked);
		if (table_sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/dsot_pkg.sv
hdl/dsot_ram.sv
hdl/depth_sorted_object_table.sv
tb/sv/tb.sv
